// ===== rtl/interrupt_vector_block_allocator_core_defines.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included inside module bodies that declare clk and rst.
`ifndef INTERRUPT_VECTOR_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define INTERRUPT_VECTOR_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define IVBA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define IVBA_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ivba_pkg.sv =====
// Shared types and codes for the interrupt vector block allocator.
// Depends on nothing.
package ivba_pkg;

  localparam int MODE_W   = 2;
  localparam int RANGE_W  = 9;
  localparam int STATUS_W = 2;
  localparam int VEC_W    = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIPE,
    S_READ,
    S_TEST,
    S_CLAIM,
    S_OUT
  } state_t;

endpackage

// ===== rtl/interrupt_vector_block_allocator_core.sv =====
// Interrupt vector block allocator: occupancy memory, scan sequencer, result register.
// Depends on ivba_pkg and interrupt_vector_block_allocator_core_defines.svh.
// Sequence: unused-mode, not-initialized, bad-range and oversized requests go straight to S_OUT;
//   a clear wipes the map one entry per cycle, then answers. Allocations test each entry in
//   S_READ, then S_TEST (read, then check), then mark the block one entry per cycle in S_CLAIM.
// Throughput: one request at a time; s_tready is high only while idle.
// Reset (rst, synchronous, active high): not initialized, no result; the map is wiped by clear.
module interrupt_vector_block_allocator_core #(
  parameter int NUM_VECTORS   = 256,
  parameter int FIRST_DYNAMIC = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [8:0] range, rest zero
  input  logic [ivba_pkg::MODE_W-1:0] s_tuser,   // [1:0] mode
  // result channel
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] vector
  output logic [ivba_pkg::STATUS_W-1:0] m_tuser  // [1:0] status
);
  import ivba_pkg::*;

  `include "interrupt_vector_block_allocator_core_defines.svh"

  // Index width, counter width (can hold NUM_VECTORS), end-of-block width.
  localparam int IW = $clog2(NUM_VECTORS);
  localparam int CW = IW + 1;
  localparam int EW = CW + 1;

  localparam logic [CW-1:0] FD_C   = CW'(FIRST_DYNAMIC);
  localparam logic [CW-1:0] LAST_C = CW'(NUM_VECTORS - 1);
  localparam logic [EW-1:0] NV_E   = EW'(NUM_VECTORS);

  // Occupancy map: one flag per vector, one access per cycle with a registered read.
  logic                   occ_mem [NUM_VECTORS];
  logic                   occ_rd;
  logic                   initialized;

  state_t state, state_next;

  // Sequencer registers: scan index, candidate base, block length.
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       base, base_next;
  logic [CW-1:0]       len, len_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [VEC_W-1:0]    res_vector, res_vector_next;

  logic [MODE_W-1:0]  req_mode;
  logic [RANGE_W-1:0] req_range;
  logic               accept;
  logic               out_free;

  // Shared arithmetic: end of the candidate block and the alignment mask.
  logic [CW-1:0] mask;
  logic [EW-1:0] end_sum;
  logic [EW-1:0] last_idx;
  logic          claim_done;

  // Start-of-search computation for a newly accepted length.
  logic [CW-1:0]      new_len;
  logic [CW-1:0]      new_mask;
  logic [CW-1:0]      start_raw;
  logic [EW-1:0]      start_up;
  logic               range_pow2;
  logic               range_big;

  // Terms for the checks at the end.
  logic               fail_out;
  logic               out_stall;
  logic               in_block;

  assign req_mode  = s_tuser;
  assign req_range = s_tdata[RANGE_W-1:0];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign mask     = len - CW'(1);
  assign end_sum  = {1'b0, base} + {1'b0, len};
  assign last_idx = end_sum - EW'(1);
  assign claim_done = ({1'b0, idx} == last_idx);

  assign range_pow2 = (req_range != '0) && ((req_range & (req_range - RANGE_W'(1))) == '0);
  assign range_big  = ({1'b0, req_range} >= (RANGE_W + 1)'(NUM_VECTORS));

  assign fail_out  = m_tvalid && (m_tuser != ST_OK);
  assign out_stall = m_tvalid && !m_tready;
  assign in_block  = (idx >= base) && ({1'b0, idx} < end_sum);

  always_comb begin
    if (req_mode == MODE_SINGLE) begin
      new_len = CW'(1);
    end else begin
      new_len = req_range[CW-1:0];
    end
    new_mask  = new_len - CW'(1);
    start_raw = (new_len > FD_C) ? new_len : FD_C;
    // Round the search start up to a multiple of the block length.
    start_up  = ({1'b0, start_raw} + {1'b0, new_mask}) & ~{1'b0, new_mask};
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_mode == MODE_CLEAR) begin
            state_next = S_WIPE;
          end else if (req_mode == MODE_UNUSED || !initialized) begin
            state_next = S_OUT;
          end else if (req_mode == MODE_SINGLE) begin
            state_next = S_READ;
          end else if (!range_pow2 || range_big) begin
            state_next = S_OUT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_WIPE: begin
        if (idx == LAST_C) begin
          state_next = S_OUT;
        end
      end
      S_READ: begin
        if (end_sum > NV_E) begin
          state_next = S_OUT;
        end else begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (!occ_rd && claim_done) begin
          state_next = S_CLAIM;
        end else begin
          state_next = S_READ;
        end
      end
      S_CLAIM: begin
        if (claim_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and result logic.
  always_comb begin
    idx_next        = idx;
    base_next       = base;
    len_next        = len;
    res_status_next = res_status;
    res_vector_next = res_vector;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_vector_next = '0;
          len_next        = new_len;
          base_next       = start_up[CW-1:0];
          idx_next        = start_up[CW-1:0];
          if (req_mode == MODE_CLEAR) begin
            idx_next        = '0;
            res_status_next = ST_OK;
          end else if (req_mode == MODE_UNUSED) begin
            res_status_next = ST_BAD_RANGE;
          end else if (!initialized) begin
            res_status_next = ST_NOT_INIT;
          end else if (req_mode == MODE_BLOCK && !range_pow2) begin
            res_status_next = ST_BAD_RANGE;
          end else if (req_mode == MODE_BLOCK && range_big) begin
            res_status_next = ST_NO_SPACE;
          end else begin
            res_status_next = ST_OK;
          end
        end
      end
      S_WIPE: begin
        idx_next = idx + CW'(1);
      end
      S_READ: begin
        if (end_sum > NV_E) begin
          res_status_next = ST_NO_SPACE;
          res_vector_next = '0;
        end
      end
      S_TEST: begin
        if (occ_rd) begin
          // Skip to the next aligned block past the occupied entry.
          base_next = (idx | mask) + CW'(1);
          idx_next  = (idx | mask) + CW'(1);
        end else if (claim_done) begin
          idx_next = base;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      S_CLAIM: begin
        if (claim_done) begin
          res_status_next = ST_OK;
          res_vector_next = VEC_W'(base[IW-1:0]);
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      initialized <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req_mode == MODE_CLEAR) begin
        initialized <= 1'b1;
      end
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Map port: wipe or mark the entry at idx; read it back through the occ_rd register.
  always_ff @(posedge clk) begin
    if (state == S_WIPE) begin
      occ_mem[idx[IW-1:0]] <= 1'b0;
    end else if (state == S_CLAIM) begin
      occ_mem[idx[IW-1:0]] <= 1'b1;
    end
    occ_rd <= occ_mem[idx[IW-1:0]];
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    base       <= base_next;
    len        <= len_next;
    res_status <= res_status_next;
    res_vector <= res_vector_next;
    if (state == S_OUT && out_free) begin
      m_tuser <= res_status;
      m_tdata <= res_vector;
    end
  end

  // A failed request never reports a vector.
  `IVBA_CHECK(a_fail_zero, fail_out |-> (m_tdata == '0), "failed result carries a vector")
  // A stalled result stays valid and unchanged.
  `IVBA_CHECK(a_hold, out_stall |=> m_tvalid && $stable({m_tuser, m_tdata}), "result lost")
  // The tested entry stays inside the current candidate block.
  `IVBA_CHECK(a_scan_in_block, (state == S_TEST) |-> in_block, "scan index left the block")
  // Candidate blocks stay aligned to their length.
  `IVBA_CHECK(a_scan_aligned, (state == S_READ) |-> ((base & mask) == '0), "block misaligned")
  // Marking stays inside the map.
  `IVBA_CHECK(a_claim_in_map, (state == S_CLAIM) |-> ({1'b0, idx} < NV_E), "claim past the map")

endmodule
